// ===== design/two_phase_thermostat_macros.svh =====
// assertion helpers for the two-phase thermostat
// every check is clocked on clk and held off while arst_n is low
`ifndef TWO_PHASE_THERMOSTAT_MACROS_SVH
`define TWO_PHASE_THERMOSTAT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold on every edge
`define TPT_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("two_phase_thermostat check failed");

// property that must hold on the edge after a condition
`define TPT_ASSERT_NEXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("two_phase_thermostat check failed");

`else

`define TPT_ASSERT(label, prop)
`define TPT_ASSERT_NEXT(label, cond, prop)

`endif

`endif

// ===== design/tpt_pkg.sv =====
package tpt_pkg;

	localparam int unsigned CfgIdxW  = 8;
	localparam int unsigned CfgDataW = 16;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] CFG_FIRST_TARGET  = 8'd0;
	localparam logic [CfgIdxW-1:0] CFG_SECOND_TARGET = 8'd1;
	localparam logic [CfgIdxW-1:0] CFG_HOLD_LIMIT    = 8'd2;
	localparam logic [CfgIdxW-1:0] CFG_HYSTERESIS    = 8'd3;

	// register reset values
	localparam logic [8:0]  FIRST_TARGET_RST  = 9'd170;
	localparam logic [8:0]  SECOND_TARGET_RST = 9'd110;
	localparam logic [15:0] HOLD_LIMIT_RST    = 16'd21600;
	localparam logic [3:0]  HYSTERESIS_RST    = 4'd1;

	// temperature = TEMP_OFFSET - sample / 6
	// sample / 6 is exact as (sample * 683) >> 12 over the whole 10-bit range
	localparam logic [8:0] TEMP_OFFSET   = 9'd260;
	localparam logic [9:0] DIV6_RECIP    = 10'd683;
	localparam int unsigned DIV6_SHIFT   = 12;

	typedef enum logic [0:0] {
		PHASE_WARM = 1'b0,
		PHASE_HOLD = 1'b1
	} phase_t;

endpackage

// ===== design/two_phase_thermostat.sv =====
// two_phase_thermostat: one result item per sample item
// a sample passes through the sample register and then the result register
// throughput: one item per cycle while out_stall is low; output register frees as the result is taken
// state update (phase, hold count, heater, led, parity) is combinational between registers
// reset (arst_n low, async): warm phase, heater on, led off, hold count 0, even parity,
// registers at 170 / 110 / 21600 / 1, both pipeline stages empty
`include "two_phase_thermostat_macros.svh"

module two_phase_thermostat
	import tpt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	// sample channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [9:0]          adc_sample,

	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                heater_drive,
	output logic                led_drive,
	output logic                phase_out,
	output logic [8:0]          temperature,

	// configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	// configuration registers
	logic [8:0]  first_target_q;
	logic [8:0]  second_target_q;
	logic [15:0] hold_limit_q;
	logic [3:0]  hysteresis_q;

	// sample stage
	logic        valid_s1;
	logic [9:0]  sample_s1;

	// controller state; heater, led and phase double as the result fields
	phase_t      phase_q;
	logic [16:0] hold_cnt_q;
	logic        heater_q;
	logic        led_q;
	logic        parity_q;
	logic        out_valid_q;
	logic [8:0]  temp_q;

	// handshake
	logic        out_load;
	logic        in_take;

	// next-state logic
	logic [19:0] div_prod;
	logic [7:0]  quot;
	logic [8:0]  temp_c;
	phase_t      phase_nx;
	logic [16:0] hold_cnt_nx;
	logic [8:0]  target_c;
	logic [9:0]  upper_c;
	logic [9:0]  temp_plus_hyst;
	logic        heater_nx;
	logic        led_nx;
	logic        parity_nx;

	// configuration is always taken at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_target_q  <= FIRST_TARGET_RST;
			second_target_q <= SECOND_TARGET_RST;
			hold_limit_q    <= HOLD_LIMIT_RST;
			hysteresis_q    <= HYSTERESIS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FIRST_TARGET:  first_target_q  <= cfg_data[8:0];
				CFG_SECOND_TARGET: second_target_q <= cfg_data[8:0];
				CFG_HOLD_LIMIT:    hold_limit_q    <= cfg_data[15:0];
				CFG_HYSTERESIS:    hysteresis_q    <= cfg_data[3:0];
				default: ; // unknown index, write dropped
			endcase
		end
	end

	// result register loads when empty or being drained this cycle
	assign out_load = valid_s1 && (!out_valid_q || !out_stall);
	// sample register takes a new item when empty or moving on
	assign in_stall = valid_s1 && !out_load;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_s1 <= adc_sample;
		end
	end

	// sample to degrees: divide by 6 through the reciprocal
	assign div_prod = {10'd0, sample_s1} * {10'd0, DIV6_RECIP};
	assign quot     = div_prod[DIV6_SHIFT +: 8];
	assign temp_c   = TEMP_OFFSET - {1'b0, quot};

	always_comb begin
		phase_nx    = phase_q;
		hold_cnt_nx = hold_cnt_q;
		target_c    = first_target_q;
		if (phase_q == PHASE_WARM) begin
			// first tick above the warm target switches over and already aims at the hold target
			if (temp_c > first_target_q) begin
				phase_nx = PHASE_HOLD;
				target_c = second_target_q;
			end
		end else begin
			if (hold_cnt_q > {1'b0, hold_limit_q}) begin
				// hold time is over, heater aims at zero
				target_c = 9'd0;
			end else begin
				hold_cnt_nx = hold_cnt_q + 17'd1;
				target_c    = second_target_q;
			end
		end
	end

	// dead band compared in unsigned form:
	// temp > target + hyst switches off, temp + hyst < target switches on
	// (the second form also covers a dead band that reaches below zero)
	assign upper_c        = {1'b0, target_c} + {6'd0, hysteresis_q};
	assign temp_plus_hyst = {1'b0, temp_c} + {6'd0, hysteresis_q};

	always_comb begin
		heater_nx = heater_q;
		if ({1'b0, temp_c} > upper_c) begin
			heater_nx = 1'b0;
		end
		if (temp_plus_hyst < {1'b0, target_c}) begin
			heater_nx = 1'b1;
		end
	end

	// tick count flips first, so the first item is an odd tick
	assign parity_nx = ~parity_q;

	always_comb begin
		if (heater_nx) begin
			led_nx = 1'b1;
		end else if (phase_nx == PHASE_WARM || !parity_nx) begin
			// blink: every tick while warming, even ticks while holding
			led_nx = ~led_q;
		end else begin
			led_nx = led_q;
		end
	end

	// state and result advance together, once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PHASE_WARM;
			hold_cnt_q <= 17'd0;
			heater_q   <= 1'b1;
			led_q      <= 1'b0;
			parity_q   <= 1'b0;
		end else if (out_load) begin
			phase_q    <= phase_nx;
			hold_cnt_q <= hold_cnt_nx;
			heater_q   <= heater_nx;
			led_q      <= led_nx;
			parity_q   <= parity_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			temp_q <= temp_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign heater_drive = heater_q;
	assign led_drive    = led_q;
	assign phase_out    = phase_q;
	assign temperature  = temp_q;

	// the hold phase is never left once entered
	`TPT_ASSERT_NEXT(a_phase_sticky, phase_q == PHASE_HOLD, phase_q == PHASE_HOLD)
	// hold ticks are only counted in the hold phase
	`TPT_ASSERT(a_count_in_hold, (hold_cnt_q != 17'd0) |-> (phase_q == PHASE_HOLD))
	// a delivered result with the heater on always shows the led lit
	`TPT_ASSERT(a_led_with_heater, (out_valid_q && heater_q) |-> led_q)
	// tick parity only moves when an item completes
	`TPT_ASSERT_NEXT(a_parity_holds, !out_load, $stable(parity_q))
	// the counter stops one past the largest limit
	`TPT_ASSERT(a_count_bound, hold_cnt_q <= 17'd65536)

endmodule

// ===== dv/two_phase_thermostat_tb.sv =====
module two_phase_thermostat_tb;
	import tpt_pkg::*;

	// register indexes the block does not decode, writes must be dropped
	localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 8'd4;
	localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 8'd255;

	localparam int DRAIN_CYCLES = 4;    // two-stage pipe plus margin
	localparam int REPORT_LIMIT = 10;
	localparam int RUN_PHASES   = 12;
	localparam int PHASE_ITEMS  = 140;

	// one result item as the block reports it
	typedef struct packed {
		logic       heater;
		logic       led;
		phase_t     ph;
		logic [8:0] temp;
	} thermo_result_t;

	// directed row: sample plus an optional hand-worked result
	typedef struct {
		logic [9:0]     sample;
		bit             typed;
		thermo_result_t want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [9:0]          adc_sample = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                heater_drive;
	logic                led_drive;
	logic                phase_out;
	logic [8:0]          temperature;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;

	two_phase_thermostat dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.adc_sample   (adc_sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.heater_drive (heater_drive),
		.led_drive    (led_drive),
		.phase_out    (phase_out),
		.temperature  (temperature),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("two_phase_thermostat test failed");
		$finish;
	end

	// shadow copy of the configuration registers
	logic [8:0]  first_tgt  = FIRST_TARGET_RST;
	logic [8:0]  second_tgt = SECOND_TARGET_RST;
	logic [15:0] hold_lim   = HOLD_LIMIT_RST;
	logic [3:0]  hyst_band  = HYSTERESIS_RST;

	// thermostat state as predicted
	phase_t      ph_now      = PHASE_WARM;
	logic [16:0] hold_cnt    = '0;
	logic        heater_pred = 1'b1;
	logic        led_lit     = 1'b0;
	logic        odd_tick    = 1'b0;

	thermo_result_t pending_readings[$];

	int sender_idle_pct = 0;
	int stall_pct       = 0;
	int samples_sent    = 0;
	int results_checked = 0;
	int bad_readings    = 0;

	// hand-worked rows use the reset settings: 170 / 110 / 21600 / 1
	dir_row_t directed_rows [0:24] = '{
		// coldest reading, heater stays on
		'{10'd1023, 1'b1, '{1'b1, 1'b1, PHASE_WARM, 9'd90}},
		// exactly at the warm target, no phase change yet
		'{10'd540,  1'b1, '{1'b1, 1'b1, PHASE_WARM, 9'd170}},
		// one degree over: hold phase, heater decided against the hold target
		'{10'd539,  1'b1, '{1'b0, 1'b1, PHASE_HOLD, 9'd171}},
		// hottest reading, even tick so the led toggles off
		'{10'd0,    1'b1, '{1'b0, 1'b0, PHASE_HOLD, 9'd260}},
		// walk through the dead band around the hold target
		'{10'd894,  1'b0, '0},
		'{10'd900,  1'b0, '0},
		'{10'd906,  1'b0, '0},
		'{10'd912,  1'b0, '0},
		'{10'd918,  1'b0, '0},
		'{10'd900,  1'b0, '0},
		'{10'd888,  1'b0, '0},
		'{10'd1023, 1'b0, '0},
		// walking ones across the sample
		'{10'd1,    1'b0, '0},
		'{10'd2,    1'b0, '0},
		'{10'd4,    1'b0, '0},
		'{10'd8,    1'b0, '0},
		'{10'd16,   1'b0, '0},
		'{10'd32,   1'b0, '0},
		'{10'd64,   1'b0, '0},
		'{10'd128,  1'b0, '0},
		'{10'd256,  1'b0, '0},
		'{10'd512,  1'b0, '0},
		'{10'd1020, 1'b0, '0},
		'{10'd682,  1'b0, '0},
		'{10'd341,  1'b0, '0}
	};

	// advance the predicted thermostat by one tick
	function automatic thermo_result_t predict_tick(input logic [9:0] s);
		int deg;
		int aim;
		int band;
		thermo_result_t r;
		deg  = 260 - int'(s / 10'd6);
		band = int'(hyst_band);
		odd_tick = ~odd_tick;
		if (ph_now == PHASE_WARM) begin
			if (deg > int'(first_tgt)) begin
				ph_now = PHASE_HOLD;
				aim = int'(second_tgt);
			end else begin
				aim = int'(first_tgt);
			end
		end else if (hold_cnt > hold_lim) begin
			// hold time used up, heat toward zero
			aim = 0;
		end else begin
			hold_cnt = hold_cnt + 17'd1;
			aim = int'(second_tgt);
		end
		// signed compare, a negative lower edge never switches on
		if (deg > aim + band)
			heater_pred = 1'b0;
		if (deg < aim - band)
			heater_pred = 1'b1;
		if (heater_pred)
			led_lit = 1'b1;
		else if (ph_now == PHASE_WARM || !odd_tick)
			led_lit = ~led_lit;
		r.heater = heater_pred;
		r.led    = led_lit;
		r.ph     = ph_now;
		r.temp   = 9'(deg);
		return r;
	endfunction

	// mostly readings close to the current set point, the rest anywhere
	function automatic logic [9:0] pick_sample();
		int aim;
		int deg;
		int s;
		if (ph_now == PHASE_WARM)
			aim = int'(first_tgt);
		else if (hold_cnt > hold_lim)
			aim = 0;
		else
			aim = int'(second_tgt);
		if ($urandom_range(0, 99) < 30)
			return 10'($urandom_range(0, 1023));
		deg = aim + int'($urandom_range(0, 2 * int'(hyst_band) + 4)) - (int'(hyst_band) + 2);
		if (deg < 90)
			deg = 90;
		if (deg > 260)
			deg = 260;
		s = (260 - deg) * 6 + int'($urandom_range(0, 5));
		if (s > 1023)
			s = 1023;
		return 10'(s);
	endfunction

	task automatic log_mismatch(input string what);
		bad_readings++;
		if (bad_readings <= REPORT_LIMIT)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// idle mix: sender 27 / receiver 79, then swapped, then none
	task automatic set_idle(input int mode);
		case (mode)
			0: begin
				sender_idle_pct = 27;
				stall_pct       = 79;
			end
			1: begin
				sender_idle_pct = 79;
				stall_pct       = 27;
			end
			default: begin
				sender_idle_pct = 0;
				stall_pct       = 0;
			end
		endcase
	endtask

	// offer one sample item, hold it until taken, then predict its result
	task automatic send_sample(input logic [9:0] s, input bit typed, input thermo_result_t want);
		thermo_result_t predicted;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		adc_sample <= s;
		do
			@(posedge clk);
		while (in_stall);
		predicted = predict_tick(s);
		// hand-worked rows are checked against their own value
		pending_readings.push_back(typed ? want : predicted);
		samples_sent++;
	endtask

	// one register write; the caller drops cfg_valid after the last one
	task automatic reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_FIRST_TARGET:  first_tgt  = val[8:0];
			CFG_SECOND_TARGET: second_tgt = val[8:0];
			CFG_HOLD_LIMIT:    hold_lim   = val;
			CFG_HYSTERESIS:    hyst_band  = val[3:0];
			default: ;
		endcase
	endtask

	// stop sending, wait for every result, then let the pipe settle
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register settings for one stretch of random items
	task automatic setup_phase(input int p);
		case (p % 6)
			0: begin
				// top of every range
				reg_write(CFG_FIRST_TARGET, 16'd511);
				reg_write(CFG_SECOND_TARGET, 16'd511);
				reg_write(CFG_HOLD_LIMIT, 16'hFFFF);
				reg_write(CFG_HYSTERESIS, 16'd15);
			end
			1: begin
				// target below the band, heater can never come on
				reg_write(CFG_SECOND_TARGET, 16'd0);
				reg_write(CFG_HYSTERESIS, 16'd15);
				reg_write(CFG_SPARE_LO, 16'h1234);
			end
			2: begin
				// no dead band, hold time runs out inside this stretch
				reg_write(CFG_HYSTERESIS, 16'd0);
				reg_write(CFG_SECOND_TARGET, 16'($urandom_range(90, 260)));
				reg_write(CFG_HOLD_LIMIT, 16'(hold_cnt + $urandom_range(10, 80)));
			end
			3: begin
				// limit raised past the count, hold target comes back
				reg_write(CFG_HOLD_LIMIT, 16'(hold_cnt + $urandom_range(20, 100)));
				reg_write(CFG_SECOND_TARGET, 16'($urandom_range(90, 260)));
				reg_write(CFG_HYSTERESIS, 16'($urandom_range(1, 6)));
				reg_write(CFG_FIRST_TARGET, 16'd0);
			end
			4: begin
				// limit lowered under the count, count is kept
				reg_write(CFG_HOLD_LIMIT, 16'd0);
				reg_write(CFG_SPARE_HI, 16'($urandom));
				reg_write(CFG_HYSTERESIS, 16'($urandom_range(0, 15)));
			end
			default: begin
				reg_write(CFG_FIRST_TARGET, 16'($urandom_range(0, 511)));
				reg_write(CFG_SECOND_TARGET, 16'($urandom_range(0, 511)));
				reg_write(CFG_HOLD_LIMIT, 16'($urandom_range(0, 65535)));
				reg_write(CFG_HYSTERESIS, 16'($urandom_range(0, 15)));
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	// compare one taken result item against the oldest prediction
	task automatic check_reading();
		thermo_result_t got;
		thermo_result_t want;
		got.heater = heater_drive;
		got.led    = led_drive;
		got.ph     = phase_t'(phase_out);
		got.temp   = temperature;
		results_checked++;
		if (pending_readings.size() == 0) begin
			log_mismatch($sformatf("result h%0b l%0b p%0b t%0d with nothing outstanding",
				got.heater, got.led, got.ph, got.temp));
			return;
		end
		want = pending_readings.pop_front();
		if (got !== want)
			log_mismatch($sformatf("expected h%0b l%0b p%0b t%0d, got h%0b l%0b p%0b t%0d",
				want.heater, want.led, want.ph, want.temp,
				got.heater, got.led, got.ph, got.temp));
	endtask

	// result side: take, check, and pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_reading();
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows run on the reset settings
		set_idle(0);
		foreach (directed_rows[i])
			send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].want);
		settle();

		// random stretches, each under its own register settings
		for (int p = 0; p < RUN_PHASES; p++) begin
			setup_phase(p);
			set_idle(p * 3 / RUN_PHASES);
			repeat (PHASE_ITEMS)
				send_sample(pick_sample(), 1'b0, '0);
			settle();
		end

		$display("ran %0d samples under %0d register settings, %0d results compared",
			samples_sent, RUN_PHASES + 1, results_checked);
		$display("final hold count %0d, %0d bad results", hold_cnt, bad_readings);
		if (bad_readings == 0) begin
			$display("two_phase_thermostat test passed");
		end else begin
			$display("two_phase_thermostat test failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+design
design/tpt_pkg.sv
design/two_phase_thermostat.sv
dv/two_phase_thermostat_tb.sv
